// File: rtl/byte_ring_fifo_top_defines.svh
// Assertion macros shared by the byte ring FIFO RTL.
// No dependencies; included by modules that carry assertions.
`ifndef BYTE_RING_FIFO_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_TOP_DEFINES_SVH

// clocked check, off while reset is asserted
`define BRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check with an explicit enable term
`define BRF_ASSERT_IF(lbl, en, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (en) |-> (prop)) \
        else $error(msg);

`endif

// File: rtl/brf_pkg.sv
// Package for the byte ring FIFO: sizes, operation codes, FSM states and
// the controller-to-datapath command struct. No dependencies.
package brf_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;

    localparam int S_TDATA_W = ((BYTE_W + CNT_W + 7) / 8) * 8;
    localparam int RES_W     = 1 + BYTE_W + CNT_W + CNT_W + 1 + 1;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ,
        MODE_DEQ,
        MODE_PEEK,
        MODE_DISC,
        MODE_CLR
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

// File: rtl/brf_ctrl.sv
// Transfer sequencer of the byte ring FIFO: accept, execute, deliver.
// Depends on brf_pkg and byte_ring_fifo_top_defines.svh.
`include "byte_ring_fifo_top_defines.svh"

module brf_ctrl
    import brf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ctl_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // result register must be free or emptied at this edge
                if (!out_valid_reg || m_tready) begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    `BRF_ASSERT_IF(a_exec_free, cmd.exec, !m_tvalid || m_tready, "result overwritten before transfer")
    `BRF_ASSERT_IF(a_exec_out, cmd.exec, ##1 m_tvalid, "executed item not presented")
    `BRF_ASSERT_IF(a_hold_valid, m_tvalid && !m_tready, ##1 m_tvalid, "result withdrawn early")

endmodule

// File: rtl/brf_datapath.sv
// Datapath of the byte ring FIFO: capacity register, head and fill, byte store,
// ring index wrap, result register. Depends on brf_pkg, byte_ring_fifo_top_defines.svh.
`include "byte_ring_fifo_top_defines.svh"

module brf_datapath
    import brf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctl_cmd_t             cmd,
    input  logic [MODE_W-1:0]    op_mode,
    input  logic [BYTE_W-1:0]    op_data,
    input  logic [CNT_W-1:0]     op_count,
    input  logic                 cfg_write,
    input  logic [CNT_W-1:0]     cfg_value,
    output logic [RES_W-1:0]     result
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]  cap_reg;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [MODE_W-1:0] mode_reg;
    logic [BYTE_W-1:0] din_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [BYTE_W-1:0] rd_reg;
    logic [RES_W-1:0]  res_reg, res_next;

    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  step;
    logic [CNT_W:0]    sum;
    logic [CNT_W:0]    wrapped;
    logic [CNT_W-1:0]  rem;
    logic              ok;
    logic              wr_en;
    logic [BYTE_W-1:0] dout;

    assign cap_eff = (cap_reg == '0) ? ONE_C : ((cap_reg > DEPTH_C) ? DEPTH_C : cap_reg);
    assign rem     = (cnt_reg > fill_reg) ? fill_reg : cnt_reg;

    always_comb begin
        case (mode_reg)
            MODE_ENQ: step = fill_reg;
            MODE_DEQ: step = ONE_C;
            default:  step = rem;
        endcase
    end

    // head < cap and step <= cap, so one subtract wraps the index
    assign sum     = {1'b0, CNT_W'(head_reg)} + {1'b0, step};
    assign wrapped = (sum >= {1'b0, cap_eff}) ? (sum - {1'b0, cap_eff}) : sum;

    always_comb begin
        ok        = 1'b0;
        wr_en     = 1'b0;
        dout      = '0;
        head_next = head_reg;
        fill_next = fill_reg;
        case (mode_reg)
            MODE_ENQ: begin
                if (fill_reg < cap_eff) begin
                    ok        = 1'b1;
                    wr_en     = 1'b1;
                    fill_next = fill_reg + ONE_C;
                end
            end
            MODE_DEQ: begin
                if (fill_reg != '0) begin
                    ok        = 1'b1;
                    dout      = rd_reg;
                    fill_next = fill_reg - ONE_C;
                    head_next = (fill_next == '0) ? '0 : wrapped[ADDR_W-1:0];
                end
            end
            MODE_PEEK: begin
                if (fill_reg != '0) begin
                    ok   = 1'b1;
                    dout = rd_reg;
                end
            end
            MODE_DISC: begin
                ok        = 1'b1;
                fill_next = fill_reg - rem;
                head_next = (fill_next == '0) ? '0 : wrapped[ADDR_W-1:0];
            end
            MODE_CLR: begin
                ok        = 1'b1;
                fill_next = '0;
                head_next = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        res_next = {(fill_next == cap_eff),
                    (fill_next == '0),
                    fill_next,
                    ((mode_reg == MODE_DISC) ? rem : CNT_W'(0)),
                    dout,
                    ok};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= DEPTH_C;
            head_reg <= '0;
            fill_reg <= '0;
        end else if (cfg_write) begin
            cap_reg  <= cfg_value;
            head_reg <= '0;
            fill_reg <= '0;
        end else if (cmd.exec) begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= op_mode;
            din_reg  <= op_data;
            cnt_reg  <= op_count;
        end
        if (cmd.exec) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[head_reg];
        if (cmd.exec && wr_en) begin
            mem[wrapped[ADDR_W-1:0]] <= din_reg;
        end
    end

    assign result = res_reg;

    `BRF_ASSERT(a_fill_cap, fill_reg <= cap_eff, "fill exceeds ring capacity")
    `BRF_ASSERT_IF(a_head_zero, fill_reg == '0, head_reg == '0, "head not zero on empty ring")
    `BRF_ASSERT_IF(a_head_cap, fill_reg != '0, CNT_W'(head_reg) < cap_eff, "head outside ring")

endmodule

// File: rtl/byte_ring_fifo_top.sv
// Top level of the byte ring FIFO: stream ports, config port, controller
// and datapath. Depends on brf_pkg, brf_ctrl and brf_datapath.
//
// One operation (enqueue, dequeue, peek, discard, clear) per input transfer,
// one result transfer per operation. The accepting cycle latches the operation
// and reads the byte store at the head; the execute state then runs it, updating
// head and fill and loading the result register, from which the result is
// offered. The controller takes the next item while a result is on offer, but
// not while an item is in the execute state, which waits on the registered
// store read. If the previous result is still untaken, a latched item waits
// in the execute state and s_tready stays low until it runs.
// Writing capacity (cfg_data, 0 acts as 1, above 256 acts as 256) empties the
// FIFO; write it only while no operation is in flight.

module byte_ring_fifo_top
    import brf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // data_in[7:0], count[16:8], zero pad
    input  logic [MODE_W-1:0]     s_tuser,   // mode[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // ok[0], data_out[8:1], removed[17:9], level[26:18], is_empty[27],
    // is_full[28], zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data
);

    ctl_cmd_t          cmd;
    logic [RES_W-1:0]  result;

    assign cfg_ready = 1'b1;

    brf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    brf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .op_mode   (s_tuser),
        .op_data   (s_tdata[BYTE_W-1:0]),
        .op_count  (s_tdata[BYTE_W+CNT_W-1:BYTE_W]),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .result    (result)
    );

    assign m_tdata = {{(M_TDATA_W-RES_W){1'b0}}, result};

endmodule

// File: verif/tb_byte_ring_fifo_top.sv
// Testbench for byte_ring_fifo_top: random and directed FIFO operations over several
// capacity settings, each result checked against an in-bench ring model.
// Depends on brf_pkg and the byte_ring_fifo_top RTL.
module tb_byte_ring_fifo_top;
    import brf_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_W'(MODE_CLR + 1);
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;
    localparam int unsigned       DRAIN_LIMIT    = 5000;

    typedef struct packed {
        logic              is_full;
        logic              is_empty;
        logic [CNT_W-1:0]  level;
        logic [CNT_W-1:0]  removed;
        logic [BYTE_W-1:0] data_out;
        logic              ok;
    } fifo_result_t;

    class fifo_checker;
        logic [BYTE_W-1:0] ring [DEPTH];
        int unsigned       head, fill, cap_reg;
        int unsigned       errors, ops_seen, results_seen;
        fifo_result_t      pending_results[$];

        function new();
            head = 0;
            fill = 0;
            cap_reg = 256;
            errors = 0;
            ops_seen = 0;
            results_seen = 0;
        endfunction

        function int unsigned ring_len();
            if (cap_reg < 1) return 1;
            if (cap_reg > DEPTH) return DEPTH;
            return cap_reg;
        endfunction

        function void set_capacity(logic [CNT_W-1:0] v);
            cap_reg = v;
            head = 0;
            fill = 0;
        endfunction

        function void note_op(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] din,
                              logic [CNT_W-1:0] cnt);
            fifo_result_t r;
            int unsigned  cap, rem;
            r = '0;
            cap = ring_len();
            case (m)
                MODE_ENQ: begin
                    if (fill < cap) begin
                        ring[(head + fill) % cap] = din;
                        fill++;
                        r.ok = 1'b1;
                    end
                end
                MODE_DEQ: begin
                    if (fill > 0) begin
                        r.data_out = ring[head % cap];
                        fill--;
                        head = (fill == 0) ? 0 : (head + 1) % cap;
                        r.ok = 1'b1;
                    end
                end
                MODE_PEEK: begin
                    if (fill > 0) begin
                        r.data_out = ring[head % cap];
                        r.ok = 1'b1;
                    end
                end
                MODE_DISC: begin
                    rem = (cnt > fill) ? fill : cnt;
                    fill -= rem;
                    head = (fill == 0) ? 0 : (head + rem) % cap;
                    r.removed = CNT_W'(rem);
                    r.ok = 1'b1;
                end
                MODE_CLR: begin
                    head = 0;
                    fill = 0;
                    r.ok = 1'b1;
                end
                default: ;
            endcase
            r.level = CNT_W'(fill);
            r.is_empty = (fill == 0);
            r.is_full = (fill == cap);
            pending_results.push_back(r);
            ops_seen++;
        endfunction

        function void cmp_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] td);
            fifo_result_t got, want;
            got = fifo_result_t'(td[RES_W-1:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending: %h", td);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            cmp_field("ok", CNT_W'(want.ok), CNT_W'(got.ok));
            cmp_field("data_out", CNT_W'(want.data_out), CNT_W'(got.data_out));
            cmp_field("removed", want.removed, got.removed);
            cmp_field("level", want.level, got.level);
            cmp_field("is_empty", CNT_W'(want.is_empty), CNT_W'(got.is_empty));
            cmp_field("is_full", CNT_W'(want.is_full), CNT_W'(got.is_full));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data;

    fifo_checker board = new();
    int unsigned cap_writes = 0;

    always #5 aclk = ~aclk;

    byte_ring_fifo_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_op(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] d,
                           logic [CNT_W-1:0] c, bit no_gap = 1'b0);
        int unsigned gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= S_TDATA_W'({c, d});
        do @(posedge aclk); while (!s_tready);
        board.note_op(m, d, c);
    endtask

    task automatic drain();
        int unsigned n;
        n = 0;
        s_tvalid <= 1'b0;
        while (board.pending_results.size() > 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        if (board.pending_results.size() > 0) begin
            $error("%0d results never arrived", board.pending_results.size());
            board.errors++;
            board.pending_results.delete();
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        board.set_capacity(v);
        cfg_valid <= 1'b0;
        cap_writes++;
    endtask

    // bursts lean toward filling, draining or a mix, so full and wrap cases get reached
    task automatic run_random(int unsigned n);
        int unsigned       left, burst, enq_pct, r;
        logic [MODE_W-1:0] m;
        logic [CNT_W-1:0]  c;
        bit                dense;
        left = n;
        while (left > 0) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 10;
                default: enq_pct = 45;
            endcase
            burst = $urandom_range(1, board.ring_len() + 4);
            if (burst > 300) burst = 300;
            dense = ($urandom_range(0, 4) == 0);
            while (burst > 0 && left > 0) begin
                if ($urandom_range(0, 99) < enq_pct) begin
                    m = MODE_ENQ;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 50)      m = MODE_DEQ;
                    else if (r < 70) m = MODE_PEEK;
                    else if (r < 88) m = MODE_DISC;
                    else if (r < 94) m = MODE_CLR;
                    else             m = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
                end
                if ($urandom_range(0, 3) == 0) c = CNT_W'($urandom_range(0, 511));
                else                           c = CNT_W'($urandom_range(0, 6));
                send_op(m, BYTE_W'($urandom_range(0, 255)), c, dense);
                burst--;
                left--;
            end
        end
    endtask

    initial begin : result_sink
        int unsigned stall, stretch, r;
        bit          big_done;
        logic        rdy;
        m_tready = 1'b0;
        stall = 0;
        stretch = 0;
        big_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata);
                if (!big_done && board.results_seen == 500) begin
                    stall = 400;
                    big_done = 1'b1;
                end
            end
            if (stall > 0) begin
                stall--;
                rdy = 1'b0;
            end else if (stretch > 0) begin
                stretch--;
                rdy = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                rdy = (r < 75);
                if (r < 3)        stretch = $urandom_range(20, 80);
                else if (r >= 95) stall = $urandom_range(8, 40);
                else if (r >= 75) stall = $urandom_range(0, 2);
            end
            m_tready <= rdy;
        end
    end

    initial begin : stimulus
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_ENQ;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset capacity: empty refusals, discard on empty, unused modes, wrap to head zero
        send_op(MODE_DEQ, 8'hFF, 9'd0);
        send_op(MODE_PEEK, 8'h00, 9'h1FF);
        send_op(MODE_DISC, 8'hFF, 9'd0);
        send_op(MODE_DISC, 8'h00, 9'h1FF);
        send_op(MODE_UNUSED_LO, 8'hFF, 9'h1FF);
        send_op(MODE_UNUSED_HI, 8'h00, 9'd0);
        send_op(MODE_ENQ, 8'h00, 9'd0);
        send_op(MODE_ENQ, 8'hFF, 9'h1FF);
        send_op(MODE_PEEK, 8'h00, 9'd0);
        send_op(MODE_DEQ, 8'h00, 9'd0);
        send_op(MODE_DEQ, 8'h00, 9'd0);
        send_op(MODE_DEQ, 8'h00, 9'd0);
        send_op(MODE_ENQ, 8'h5A, 9'd0);
        send_op(MODE_ENQ, 8'hC3, 9'd0);
        send_op(MODE_ENQ, 8'h3C, 9'd0);
        send_op(MODE_DISC, 8'h00, 9'd1);
        send_op(MODE_DISC, 8'h00, 9'd256);
        send_op(MODE_ENQ, 8'h81, 9'd0);
        send_op(MODE_CLR, 8'hFF, 9'h1FF);
        send_op(MODE_PEEK, 8'h00, 9'd0);

        // single-entry ring: full refusal
        write_capacity(9'd1);
        send_op(MODE_ENQ, 8'hA5, 9'd0);
        send_op(MODE_ENQ, 8'h7E, 9'd0);
        send_op(MODE_PEEK, 8'h00, 9'd0);
        send_op(MODE_DEQ, 8'h00, 9'd0);
        send_op(MODE_DISC, 8'h00, 9'h100);

        write_capacity(9'd0);
        run_random(60);
        write_capacity(9'h1FF);
        run_random(400);
        write_capacity(9'd3);
        run_random(150);
        write_capacity(9'd256);
        run_random(120);
        write_capacity(9'd17);
        run_random(200);
        write_capacity(9'd300);
        run_random(80);
        repeat (3) begin
            write_capacity(CNT_W'($urandom_range(1, 256)));
            run_random(70);
        end
        drain();

        $display("covered %0d operations and %0d result transfers", board.ops_seen,
                 board.results_seen);
        $display("across %0d capacity writes including 0, 1, 256 and out-of-range values",
                 cap_writes);
        if (board.errors == 0) begin
            $display("tb_byte_ring_fifo_top: done, clean");
        end else begin
            $display("tb_byte_ring_fifo_top: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $error("timeout");
        $display("tb_byte_ring_fifo_top: done, errors");
        $finish;
    end

endmodule
